// ===== src/sbdpl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbdpl_pkg: shared types and constants for the device presence list
// Holds the request kind codes, the field widths and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbdpl_pkg;

  // Widths of the request and result fields.
  localparam int KindW    = 2;
  localparam int AddrW    = 7;
  localparam int IndexW   = 3;
  localparam int CountW   = 4;
  localparam int RemovedW = 4;

  // Packed stream widths, rounded up to whole bytes.
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // Request kinds carried in tuser.
  typedef enum logic [KindW-1:0] {
    KIND_PROBE = 2'd0,
    KIND_END   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the accepted request, clear result flags
    logic end_scan;    // trim the list at the cursor, rewind the cursor
    logic rd_cursor;   // read the entry at the cursor
    logic del_start;   // start a delete at the cursor
    logic rd_next;     // read the entry above the pointer
    logic wr_down;     // write the read entry at the pointer, step up
    logic del_fin;     // finish a delete: count down, removed up
    logic keep;        // matching entry kept, cursor advances
    logic ins_start;   // start an insert at the top of the list
    logic rd_prev;     // read the entry below the pointer
    logic wr_up;       // write the read entry at the pointer, step down
    logic ins_fin;     // store the address at the cursor
    logic drop;        // list full, address lost
    logic rd_idx;      // read the entry at the requested index
    logic take_entry;  // capture the read result
    logic emit;        // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  present;
    logic  cur_lt_cnt;  // cursor below count
    logic  ent_lt;      // read entry below the probed address
    logic  ent_eq;      // read entry equals the probed address
    logic  nxt_lt_cnt;  // pointer plus one below count
    logic  ptr_gt_cur;  // pointer above cursor
    logic  cnt_lt_max;  // list has room
    logic  out_free;    // output register can take a result
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/sbdpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbdpl_ctrl: sequencing controller for the device presence list
// Steps one request at a time through compare, delete and insert loops,
// issuing at most one memory read or write per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdpl_ctrl
  import sbdpl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_DELRD = 4'd4;
  localparam logic [3:0] S_DELWR = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_INSRD = 4'd7;
  localparam logic [3:0] S_INSWR = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        priority if (status_i.kind == KIND_PROBE && status_i.present) begin
          state_d = S_CHECK;
        end else if (status_i.kind == KIND_END) begin
          cmd_o.end_scan = 1'b1;
          state_d        = S_DONE;
        end else if (status_i.kind == KIND_READ) begin
          cmd_o.rd_idx = 1'b1;
          state_d      = S_READ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CHECK: begin
        if (status_i.cur_lt_cnt) begin
          cmd_o.rd_cursor = 1'b1;
          state_d         = S_CMP;
        end else begin
          state_d = S_INS;
        end
      end
      S_CMP: begin
        priority if (status_i.ent_lt) begin
          cmd_o.del_start = 1'b1;
          state_d         = S_DELRD;
        end else if (status_i.ent_eq) begin
          cmd_o.keep = 1'b1;
          state_d    = S_DONE;
        end else begin
          state_d = S_INS;
        end
      end
      S_DELRD: begin
        if (status_i.nxt_lt_cnt) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_DELWR;
        end else begin
          cmd_o.del_fin = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_DELWR: begin
        cmd_o.wr_down = 1'b1;
        state_d       = S_DELRD;
      end
      S_INS: begin
        if (status_i.cnt_lt_max) begin
          cmd_o.ins_start = 1'b1;
          state_d         = S_INSRD;
        end else begin
          cmd_o.drop = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_INSRD: begin
        if (status_i.ptr_gt_cur) begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INSWR;
        end else begin
          cmd_o.ins_fin = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_INSWR: begin
        cmd_o.wr_up = 1'b1;
        state_d     = S_INSRD;
      end
      S_READ: begin
        cmd_o.take_entry = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/sbdpl_dp.sv =====
// ----------------------------------------------------------------------------
// sbdpl_dp: datapath of the device presence list
// Holds the address memory, the count and cursor, the shift pointer, the
// latched request and the output register, and acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdpl_dp
  import sbdpl_pkg::*;
#(
  parameter int MAX_DEVICES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  input  wire logic [KindW-1:0]      kind_i,
  input  wire logic [InDataW-1:0]    data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OutDataW-1:0]        out_data_o
);

  localparam int CW = $clog2(MAX_DEVICES + 1);
  localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int XW = (CW > IndexW) ? CW : IndexW;
  localparam int OW = (CW > CountW) ? CW : CountW;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_DEVICES);

  // Latched request.
  kind_e              kind_q;
  logic [AddrW-1:0]   addr_q;
  logic               present_q;
  logic [IndexW-1:0]  idx_q;

  // List state and working registers.
  logic [CW-1:0]      count_q, cursor_q, ptr_q, removed_q;
  logic               added_q, dropped_q, entry_valid_q;
  logic [AddrW-1:0]   entry_q;

  // Memory and its ports.
  logic [AddrW-1:0]   mem [MAX_DEVICES];
  logic [AddrW-1:0]   rdata_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [AddrW-1:0]   wr_data;

  // Output register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [CW:0]        ptr_inc;
  logic [CW-1:0]      ptr_dec;
  logic [XW-1:0]      idx_x, count_x;
  logic               idx_ok;
  logic [OW-1:0]      count_w, removed_w;

  assign ptr_inc = {1'b0, ptr_q} + 1'b1;
  assign ptr_dec = ptr_q - 1'b1;
  assign idx_x   = XW'(idx_q);
  assign count_x = XW'(count_q);
  assign idx_ok  = (idx_x < count_x);

  // Status back to the controller.
  always_comb begin
    status_o.kind       = kind_q;
    status_o.present    = present_q;
    status_o.cur_lt_cnt = (cursor_q < count_q);
    status_o.ent_lt     = (rdata_q < addr_q);
    status_o.ent_eq     = (rdata_q == addr_q);
    status_o.nxt_lt_cnt = (ptr_inc < {1'b0, count_q});
    status_o.ptr_gt_cur = (ptr_q > cursor_q);
    status_o.cnt_lt_max = (count_q < MaxCount);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cursor_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    wr_data = rdata_q;
    priority if (cmd_i.rd_cursor) begin
      rd_en = 1'b1;
    end else if (cmd_i.rd_next) begin
      rd_en   = 1'b1;
      rd_addr = ptr_inc[AW-1:0];
    end else if (cmd_i.rd_prev) begin
      rd_en   = 1'b1;
      rd_addr = ptr_dec[AW-1:0];
    end else if (cmd_i.rd_idx) begin
      rd_en   = idx_ok;
      rd_addr = idx_x[AW-1:0];
    end else begin
      rd_en = 1'b0;
    end
    priority if (cmd_i.wr_down || cmd_i.wr_up) begin
      wr_en = 1'b1;
    end else if (cmd_i.ins_fin) begin
      wr_en   = 1'b1;
      wr_addr = cursor_q[AW-1:0];
      wr_data = addr_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Address memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Latched request fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_e'(kind_i);
      addr_q    <= data_i[AddrW-1:0];
      present_q <= data_i[AddrW];
      idx_q     <= data_i[AddrW+1 +: IndexW];
    end
  end

  // List count, cursor and shift pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      ptr_q    <= '0;
    end else begin
      if (cmd_i.end_scan) begin
        count_q  <= cursor_q;
        cursor_q <= '0;
      end
      if (cmd_i.del_start) begin
        ptr_q <= cursor_q;
      end
      if (cmd_i.wr_down) begin
        ptr_q <= ptr_inc[CW-1:0];
      end
      if (cmd_i.del_fin) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.keep) begin
        cursor_q <= cursor_q + 1'b1;
      end
      if (cmd_i.ins_start) begin
        ptr_q <= count_q;
      end
      if (cmd_i.wr_up) begin
        ptr_q <= ptr_dec;
      end
      if (cmd_i.ins_fin) begin
        count_q  <= count_q + 1'b1;
        cursor_q <= cursor_q + 1'b1;
      end
    end
  end

  // Result fields of the current request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      removed_q     <= '0;
      added_q       <= 1'b0;
      dropped_q     <= 1'b0;
      entry_q       <= '0;
      entry_valid_q <= 1'b0;
    end
    if (cmd_i.end_scan) begin
      removed_q <= count_q - cursor_q;
    end
    if (cmd_i.del_fin) begin
      removed_q <= removed_q + 1'b1;
    end
    if (cmd_i.ins_fin) begin
      added_q <= 1'b1;
    end
    if (cmd_i.drop) begin
      dropped_q <= 1'b1;
    end
    if (cmd_i.take_entry) begin
      entry_q       <= idx_ok ? rdata_q : '0;
      entry_valid_q <= idx_ok;
    end
  end

  assign count_w   = OW'(count_q);
  assign removed_w = OW'(removed_q);

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload, packed from the lowest bit up.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {6'd0, entry_valid_q, entry_q, dropped_q,
                     removed_w[RemovedW-1:0], added_q, count_w[CountW-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/sorted_bus_device_presence_list.sv =====
// ----------------------------------------------------------------------------
// sorted_bus_device_presence_list: ascending list of answering bus addresses
// Top level joining the sequencing controller and the list datapath.
// ----------------------------------------------------------------------------
// The block serves one request at a time. A read passes through dispatch, the
// memory read and done; an end of scan, a probe that did not acknowledge or an
// unused kind goes from dispatch straight to done. An acknowledged probe
// checks the cursor against the count before each compare of the entry at the
// cursor. A smaller entry is deleted by moving every entry above it down one
// place; an insert moves every entry from the cursor up one place and then
// stores the address at the cursor, and an address that meets a full list is
// dropped. Every entry moved costs one read and one write of the address
// memory. A finished result waits in the controller while the output register
// still holds an unaccepted one. A new request is accepted as soon as the
// controller is back in idle, even while the previous result still waits in
// the output register.
`default_nettype none

module sorted_bus_device_presence_list
  import sbdpl_pkg::*;
#(
  parameter int MAX_DEVICES = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [6:0] address, [7] present, [10:8] index, [15:11] zero
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] kind
  input  wire logic [KindW-1:0]     s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [3:0] count, [4] added, [8:5] removed, [9] dropped, [16:10] entry,
  // [17] entry_valid, [23:18] zero
  output logic [OutDataW-1:0]       m_axis_tdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sbdpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbdpl_dp #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== src/sbdpl_checker.sv =====
// ----------------------------------------------------------------------------
// sbdpl_checker: port-level checks for the device presence list
// Watches the request stream for one request at a time, and the result
// stream for consistent flags and a held result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdpl_checker
  import sbdpl_pkg::*;
#(
  parameter int MAX_DEVICES = 8
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic [CountW-1:0] res_count;
  logic              res_added, res_dropped, res_valid;
  logic [AddrW-1:0]  res_entry;

  assign res_count   = m_axis_tdata[3:0];
  assign res_added   = m_axis_tdata[4];
  assign res_dropped = m_axis_tdata[9];
  assign res_entry   = m_axis_tdata[16:10];
  assign res_valid   = m_axis_tdata[17];

  // Only one request is in flight: the input closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // The list never grows past its capacity (checked when the capacity is below 16).
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (MAX_DEVICES < 16) |-> (32'(res_count) <= MAX_DEVICES))
    else $error("count exceeds capacity");

  // A probe either inserts or drops its address, never both.
  a_add_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_added && res_dropped))
    else $error("added and dropped both set");

  // An entry is only reported together with its valid flag.
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_valid |-> (res_entry == '0))
    else $error("entry nonzero without entry_valid");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind sorted_bus_device_presence_list sbdpl_checker #(
  .MAX_DEVICES (MAX_DEVICES)
) u_sbdpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
